FILE: rtl/i2c_seq_pkg.sv
// ----------------------------------------------------------------------------
// i2c_seq_pkg
// Shared types and constants of the two-bus I2C master bit sequencer.
// ----------------------------------------------------------------------------
package i2c_seq_pkg;

    localparam int unsigned DATA_BITS      = 8;
    localparam int unsigned HALF_W         = 16;
    localparam int unsigned HALF_RESET     = 10;
    localparam int unsigned STEP_W         = 3;
    localparam int unsigned BIT_CNT_W      = 4;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4,
        OP_ACK   = 3'd5,
        OP_NACK  = 3'd6
    } opcode_t;

    typedef logic [HALF_W-1:0]    half_t;
    typedef logic [DATA_BITS-1:0] byte_t;
    typedef logic [STEP_W-1:0]    step_t;
    typedef logic [BIT_CNT_W-1:0] bit_cnt_t;

endpackage

FILE: rtl/i2c_seq_if.sv
// ----------------------------------------------------------------------------
// i2c_seq_if
// Item channels of the sequencer: command/tick items in, status items out.
// ----------------------------------------------------------------------------
interface i2c_seq_cmd_if
    import i2c_seq_pkg::*;
();
    logic    valid;
    logic    ready;
    logic [2:0] opcode;
    logic    bus_select;
    byte_t   write_byte;
    logic    sda_in_bus0;
    logic    sda_in_bus1;

    modport source (output valid, opcode, bus_select, write_byte, sda_in_bus0, sda_in_bus1,
                    input ready);
    modport sink   (input valid, opcode, bus_select, write_byte, sda_in_bus0, sda_in_bus1,
                    output ready);
endinterface

interface i2c_seq_res_if
    import i2c_seq_pkg::*;
();
    logic    valid;
    logic    ready;
    logic    scl_bus0;
    logic    sda_bus0;
    logic    scl_bus1;
    logic    sda_bus1;
    logic    busy_res;
    logic    done_res;
    logic    ack_seen;
    byte_t   read_data;
    logic    rejected;

    modport source (output valid, scl_bus0, sda_bus0, scl_bus1, sda_bus1, busy_res,
                    done_res, ack_seen, read_data, rejected,
                    input ready);
    modport sink   (input valid, scl_bus0, sda_bus0, scl_bus1, sda_bus1, busy_res,
                    done_res, ack_seen, read_data, rejected,
                    output ready);
endinterface

FILE: rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer
// Master bit sequencer for two I2C buses: start, stop, write byte, read byte,
// ack and nack sequences stepped by tick items, one status item per input.
//
//   channel    dir   handshake      carries
//   cmd        in    valid/ready    opcode, bus_select, write_byte, sda levels
//   res        out   valid/ready    scl/sda drive, busy, done, ack, data, reject
//   cfg        in    write enable   half_period_ticks
//
// one item per cycle unless res stalls; each item's status is registered and appears in the cycle after acceptance
// the output register frees cmd.ready whenever the result is taken or empty
// a stall on res holds cmd.ready low until the waiting item is taken
// reset: lines released, idle, half period 10 ticks
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer
    import i2c_seq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    i2c_seq_cmd_if.sink         cmd,
    i2c_seq_res_if.source       res,
    input  logic                cfg_write_en,
    input  logic [HALF_W-1:0]   cfg_write_data
);

    half_t    half_reg;
    step_t    step_reg,   step_next;
    half_t    tick_reg,   tick_next;
    byte_t    shift_reg,  shift_next;
    bit_cnt_t bits_reg,   bits_next;
    opcode_t  cmd_reg,    cmd_next;
    logic     bus_reg,    bus_next;
    logic [3:0] line_reg, line_next;
    logic     ack_reg,    ack_next;
    byte_t    rdata_reg,  rdata_next;

    logic     res_valid_reg;
    logic     done_reg,   done_next;
    logic     rej_reg,    rej_next;

    logic     accept;
    logic     busy;
    logic     do_step;
    logic     seq_end;
    logic     sda_now;
    half_t    hold;

    assign cmd.ready = !res_valid_reg || res.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign busy      = (cmd_reg != OP_TICK);
    assign hold      = (half_reg == '0) ? half_t'(1) : half_reg;

    always_comb
    begin
        step_next  = step_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bits_next  = bits_reg;
        cmd_next   = cmd_reg;
        bus_next   = bus_reg;
        line_next  = line_reg;
        ack_next   = ack_reg;
        rdata_next = rdata_reg;
        done_next  = 1'b0;
        rej_next   = 1'b0;
        do_step    = 1'b0;
        seq_end    = 1'b0;
        sda_now    = 1'b0;

        if (accept)
        begin
            case (cmd.opcode)
                OP_TICK:
                begin
                    if (busy)
                    begin
                        tick_next = tick_reg + half_t'(1);
                        if (tick_next >= hold)
                        begin
                            do_step = 1'b1;
                            sda_now = bus_reg ? cmd.sda_in_bus1 : cmd.sda_in_bus0;
                        end
                    end
                end
                OP_START, OP_STOP, OP_WRITE, OP_READ, OP_ACK, OP_NACK:
                begin
                    if (busy)
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        cmd_next  = opcode_t'(cmd.opcode);
                        bus_next  = cmd.bus_select;
                        step_next = '0;
                        bits_next = '0;
                        do_step   = 1'b1;
                        if (cmd.opcode == OP_WRITE)
                        begin
                            shift_next = cmd.write_byte;
                        end
                        else if (cmd.opcode == OP_READ)
                        begin
                            shift_next = '0;
                        end
                    end
                end
                default:
                begin
                    // reserved opcode, no effect
                end
            endcase
        end

        if (do_step)
        begin
            tick_next = '0;
            case (cmd_next)
                OP_START:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else if (step_next == step_t'(1))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b0;
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        step_next = step_t'(2);
                    end
                    else
                    begin
                        seq_end = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b0;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        seq_end = 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b0;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else if (step_next == step_t'(1))
                    begin
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        step_next = step_t'(2);
                    end
                    else
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        seq_end = 1'b1;
                    end
                end
                OP_NACK:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else if (step_next == step_t'(1))
                    begin
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        step_next = step_t'(2);
                    end
                    else
                    begin
                        seq_end = 1'b1;
                    end
                end
                OP_WRITE:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = shift_next[DATA_BITS-1];
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else if (step_next == step_t'(1))
                    begin
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        shift_next = {shift_next[DATA_BITS-2:0], 1'b0};
                        bits_next  = bits_next + bit_cnt_t'(1);
                        step_next  = (bits_next < bit_cnt_t'(DATA_BITS)) ? step_t'(0)
                                                                         : step_t'(2);
                    end
                    else if (step_next == step_t'(2))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(3);
                    end
                    else if (step_next == step_t'(3))
                    begin
                        ack_next = !sda_now;
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        step_next = step_t'(4);
                    end
                    else
                    begin
                        seq_end = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (step_next == step_t'(0))
                    begin
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(1);
                    end
                    else if (step_next == step_t'(1))
                    begin
                        line_next[{bus_next, 1'b0}] = 1'b1;
                        step_next = step_t'(2);
                    end
                    else if (step_next == step_t'(2))
                    begin
                        shift_next = {shift_next[DATA_BITS-2:0], sda_now};
                        line_next[{bus_next, 1'b1}] = 1'b1;
                        line_next[{bus_next, 1'b0}] = 1'b0;
                        bits_next  = bits_next + bit_cnt_t'(1);
                        step_next  = (bits_next < bit_cnt_t'(DATA_BITS)) ? step_t'(1)
                                                                         : step_t'(3);
                    end
                    else
                    begin
                        rdata_next = shift_next;
                        seq_end    = 1'b1;
                    end
                end
                default:
                begin
                    seq_end = 1'b1;
                end
            endcase
        end

        if (seq_end)
        begin
            cmd_next  = OP_TICK;
            step_next = '0;
            tick_next = '0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= half_t'(HALF_RESET);
            step_reg      <= '0;
            tick_reg      <= '0;
            shift_reg     <= '0;
            bits_reg      <= '0;
            cmd_reg       <= OP_TICK;
            bus_reg       <= 1'b0;
            line_reg      <= 4'hF;
            ack_reg       <= 1'b0;
            rdata_reg     <= '0;
            res_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                half_reg <= cfg_write_data;
            end
            if (accept)
            begin
                step_reg  <= step_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                bits_reg  <= bits_next;
                cmd_reg   <= cmd_next;
                bus_reg   <= bus_next;
                line_reg  <= line_next;
                ack_reg   <= ack_next;
                rdata_reg <= rdata_next;
                done_reg  <= done_next;
                rej_reg   <= rej_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.scl_bus0  = line_reg[0];
    assign res.sda_bus0  = line_reg[1];
    assign res.scl_bus1  = line_reg[2];
    assign res.sda_bus1  = line_reg[3];
    assign res.busy_res  = busy;
    assign res.done_res  = done_reg;
    assign res.ack_seen  = ack_reg;
    assign res.read_data = rdata_reg;
    assign res.rejected  = rej_reg;

    // a finished sequence leaves the block idle
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && done_reg |-> !busy)
        else $error("done reported while still busy");

    // a command is rejected only while a sequence is running
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && rej_reg |-> busy)
        else $error("rejection reported while idle");

    // idle means counters parked at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (step_reg == '0) && (tick_reg == '0))
        else $error("step or tick counter left running while idle");

    // a waiting result is held while the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> res_valid_reg && $stable(line_reg)
            && $stable(done_reg) && $stable(rdata_reg))
        else $error("result changed during output stall");

    // step index stays within the longest sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= step_t'(4))
        else $error("step index out of range");

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the two-bus I2C master bit sequencer. Directed
// tests cover every command on both buses, busy rejection, the reserved
// opcode, zero and maximum half periods and a half period change in the
// middle of a hold. Random command and tick traffic follows. Both channels
// stall at random. A local model of the sequencer predicts each status item,
// and a checker compares every status item field by field.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_seq_pkg::*;

    localparam logic [2:0] OP_RESERVED    = 3'd7;
    localparam logic       LINE_SCL       = 1'b0;
    localparam logic       LINE_SDA       = 1'b1;
    localparam int         SDA_LOW        = 0;
    localparam int         SDA_HIGH       = 1;
    localparam int         SDA_RANDOM     = 2;
    localparam int         WATCHDOG_LIMIT = 3000;
    localparam int         LONG_HOLD      = 300;
    localparam int         ITEM_TARGET    = 1500;

    typedef struct {
        logic [2:0] op;
        logic       bus;
        byte_t      wbyte;
        logic       sda0;
        logic       sda1;
    } cmd_item_t;

    typedef struct {
        logic  scl_bus0;
        logic  sda_bus0;
        logic  scl_bus1;
        logic  sda_bus1;
        logic  busy_res;
        logic  done_res;
        logic  ack_seen;
        byte_t read_data;
        logic  rejected;
    } status_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_write_en;
    half_t cfg_write_data;

    i2c_seq_cmd_if cmd_ch ();
    i2c_seq_res_if res_ch ();

    i2c_master_bit_sequencer uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd_ch),
        .res            (res_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    // sequencer model
    half_t       half_ticks;
    logic [4:0]  step_no;
    logic [15:0] hold_ticks;
    byte_t       shreg;
    logic [3:0]  bit_no;
    logic [2:0]  run_op;
    logic        run_bus;
    logic [3:0]  line_lv;
    logic        ack_lv;
    byte_t       last_rd;

    status_t pending_status [$];
    int      mismatches  = 0;
    int      items_sent  = 0;
    bit      src_gaps    = 1'b1;
    bit      sink_stalls = 1'b1;
    int      hold_ask    = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void clear_bus_model();
        half_ticks = half_t'(HALF_RESET);
        step_no    = '0;
        hold_ticks = '0;
        shreg      = '0;
        bit_no     = '0;
        run_op     = OP_TICK;
        run_bus    = 1'b0;
        line_lv    = 4'hF;
        ack_lv     = 1'b0;
        last_rd    = '0;
    endfunction

    function automatic void set_line(input logic is_sda, input logic level);
        line_lv[{run_bus, is_sda}] = level;
    endfunction

    // returns 1 when a hold starts, 0 when the sequence is over
    function automatic logic step_sequence(input logic sda_now);
        hold_ticks = '0;
        case (run_op)
            OP_START:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, 1'b1);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                if (step_no == 1)
                begin
                    set_line(LINE_SDA, 1'b0);
                    set_line(LINE_SCL, 1'b0);
                    step_no = 5'd2;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_STOP:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, 1'b0);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                set_line(LINE_SDA, 1'b1);
                return 1'b0;
            end
            OP_ACK:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, 1'b0);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                if (step_no == 1)
                begin
                    set_line(LINE_SCL, 1'b0);
                    step_no = 5'd2;
                    return 1'b1;
                end
                set_line(LINE_SDA, 1'b1);
                return 1'b0;
            end
            OP_NACK:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, 1'b1);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                if (step_no == 1)
                begin
                    set_line(LINE_SCL, 1'b0);
                    step_no = 5'd2;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_WRITE:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, shreg[DATA_BITS-1]);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                if (step_no == 1)
                begin
                    set_line(LINE_SCL, 1'b0);
                    shreg   = shreg << 1;
                    bit_no  = bit_no + 1'b1;
                    step_no = (bit_no < DATA_BITS) ? 5'd0 : 5'd2;
                    return 1'b1;
                end
                if (step_no == 2)
                begin
                    set_line(LINE_SDA, 1'b1);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd3;
                    return 1'b1;
                end
                if (step_no == 3)
                begin
                    ack_lv = ~sda_now;
                    set_line(LINE_SCL, 1'b0);
                    step_no = 5'd4;
                    return 1'b1;
                end
                return 1'b0;
            end
            OP_READ:
            begin
                if (step_no == 0)
                begin
                    set_line(LINE_SDA, 1'b1);
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd1;
                    return 1'b1;
                end
                if (step_no == 1)
                begin
                    set_line(LINE_SCL, 1'b1);
                    step_no = 5'd2;
                    return 1'b1;
                end
                if (step_no == 2)
                begin
                    shreg = {shreg[DATA_BITS-2:0], sda_now};
                    set_line(LINE_SDA, 1'b1);
                    set_line(LINE_SCL, 1'b0);
                    bit_no  = bit_no + 1'b1;
                    step_no = (bit_no < DATA_BITS) ? 5'd1 : 5'd3;
                    return 1'b1;
                end
                last_rd = shreg;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
        return 1'b0;
    endfunction

    function automatic status_t predict_status(input cmd_item_t it);
        status_t     r;
        logic        was_busy;
        logic        fin;
        logic        rej;
        int unsigned hp;
        was_busy = (run_op != OP_TICK);
        fin      = 1'b0;
        rej      = 1'b0;
        if (it.op == OP_TICK)
        begin
            if (was_busy)
            begin
                hp         = (half_ticks == 0) ? 1 : half_ticks;
                hold_ticks = hold_ticks + 1'b1;
                if (hold_ticks >= hp)
                begin
                    if (!step_sequence(run_bus ? it.sda1 : it.sda0))
                    begin
                        run_op     = OP_TICK;
                        step_no    = '0;
                        hold_ticks = '0;
                        fin        = 1'b1;
                    end
                end
            end
        end
        else if (it.op != OP_RESERVED)
        begin
            if (was_busy)
                rej = 1'b1;
            else
            begin
                run_op     = it.op;
                run_bus    = it.bus;
                step_no    = '0;
                hold_ticks = '0;
                bit_no     = '0;
                if (it.op == OP_WRITE)
                    shreg = it.wbyte;
                else if (it.op == OP_READ)
                    shreg = '0;
                if (!step_sequence(1'b0))
                begin
                    run_op  = OP_TICK;
                    step_no = '0;
                    fin     = 1'b1;
                end
            end
        end
        r.scl_bus0  = line_lv[0];
        r.sda_bus0  = line_lv[1];
        r.scl_bus1  = line_lv[2];
        r.sda_bus1  = line_lv[3];
        r.busy_res  = (run_op != OP_TICK);
        r.done_res  = fin;
        r.ack_seen  = ack_lv;
        r.read_data = last_rd;
        r.rejected  = rej;
        return r;
    endfunction

    function automatic cmd_item_t tick_item(input int sda_mode);
        cmd_item_t it;
        it.op    = OP_TICK;
        it.bus   = 1'($urandom_range(0, 1));
        it.wbyte = 8'($urandom_range(0, 255));
        if (sda_mode == SDA_RANDOM)
        begin
            it.sda0 = 1'($urandom_range(0, 1));
            it.sda1 = 1'($urandom_range(0, 1));
        end
        else
        begin
            it.sda0 = (sda_mode == SDA_HIGH);
            it.sda1 = (sda_mode == SDA_HIGH);
        end
        return it;
    endfunction

    task automatic send_item(input cmd_item_t it);
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= it.op;
        cmd_ch.bus_select  <= it.bus;
        cmd_ch.write_byte  <= it.wbyte;
        cmd_ch.sda_in_bus0 <= it.sda0;
        cmd_ch.sda_in_bus1 <= it.sda1;
        @(posedge clk);
        while (cmd_ch.ready !== 1'b1) @(posedge clk);
        pending_status.push_back(predict_status(it));
        items_sent++;
    endtask

    task automatic wait_drain();
        cmd_ch.valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_half_period(input half_t value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        half_ticks = value;
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    // command, then ticks until the sequence ends; noise adds commands while busy
    task automatic run_command(input logic [2:0] op, input logic bus, input byte_t wbyte,
                               input int sda_mode, input int noise);
        cmd_item_t it;
        it       = tick_item(sda_mode);
        it.op    = op;
        it.bus   = bus;
        it.wbyte = wbyte;
        send_item(it);
        while (run_op != OP_TICK)
        begin
            if (noise > 0 && $urandom_range(1, 100) <= noise)
            begin
                it    = tick_item(SDA_RANDOM);
                it.op = 3'($urandom_range(OP_START, OP_RESERVED));
                send_item(it);
            end
            send_item(tick_item(sda_mode));
        end
    endtask

    task automatic test_idle_items();
        cmd_item_t it;
        repeat (4) send_item(tick_item(SDA_RANDOM));
        it    = tick_item(SDA_RANDOM);
        it.op = OP_RESERVED;
        send_item(it);
        it.bus   = 1'b1;
        it.wbyte = 8'hFF;
        send_item(it);
    endtask

    task automatic test_each_command();
        run_command(OP_START, 1'b0, 8'h00, SDA_RANDOM, 0);
        run_command(OP_WRITE, 1'b0, 8'hA5, SDA_LOW, 0);
        run_command(OP_WRITE, 1'b0, 8'h00, SDA_HIGH, 0);
        run_command(OP_READ,  1'b0, 8'h00, SDA_HIGH, 0);
        run_command(OP_ACK,   1'b0, 8'h00, SDA_RANDOM, 0);
        run_command(OP_READ,  1'b0, 8'hFF, SDA_LOW, 0);
        run_command(OP_NACK,  1'b0, 8'h00, SDA_RANDOM, 0);
        run_command(OP_STOP,  1'b0, 8'h00, SDA_RANDOM, 0);
        wait_drain();
        write_half_period(16'd1);
        run_command(OP_START, 1'b1, 8'h00, SDA_RANDOM, 0);
        run_command(OP_WRITE, 1'b1, 8'hFF, SDA_LOW, 0);
        run_command(OP_WRITE, 1'b1, 8'h5A, SDA_HIGH, 0);
        run_command(OP_READ,  1'b1, 8'h00, SDA_RANDOM, 0);
        run_command(OP_ACK,   1'b1, 8'h00, SDA_RANDOM, 0);
        run_command(OP_NACK,  1'b1, 8'h00, SDA_RANDOM, 0);
        run_command(OP_STOP,  1'b1, 8'h00, SDA_RANDOM, 0);
    endtask

    task automatic test_rejected_commands();
        run_command(OP_WRITE, 1'b0, 8'($urandom_range(0, 255)), SDA_RANDOM, 100);
        run_command(OP_READ, 1'b1, 8'h00, SDA_RANDOM, 60);
    endtask

    task automatic test_zero_period();
        wait_drain();
        write_half_period(16'd0);
        run_command(OP_READ, 1'b0, 8'h00, SDA_RANDOM, 0);
        run_command(OP_WRITE, 1'b1, 8'hC3, SDA_RANDOM, 0);
    endtask

    task automatic test_period_change_while_busy();
        cmd_item_t it;
        wait_drain();
        write_half_period(16'hFFFF);
        it       = tick_item(SDA_RANDOM);
        it.op    = OP_WRITE;
        it.bus   = 1'b0;
        it.wbyte = 8'h3C;
        send_item(it);
        repeat (200) send_item(tick_item(SDA_RANDOM));
        wait_drain();
        write_half_period(16'd3);
        while (run_op != OP_TICK) send_item(tick_item(SDA_RANDOM));
    endtask

    task automatic test_back_pressure();
        wait_drain();
        hold_ask <= hold_ask + 1;
        run_command(OP_START, 1'b1, 8'h00, SDA_RANDOM, 0);
        repeat (40) send_item(tick_item(SDA_RANDOM));
        wait_drain();
    endtask

    task automatic test_random_traffic(input int target);
        cmd_item_t it;
        int        pick;
        while (items_sent < target)
        begin
            wait_drain();
            pick = $urandom_range(0, 9);
            if (pick == 0)
                write_half_period(16'd0);
            else if (pick == 1)
                write_half_period(half_t'($urandom_range(5, 12)));
            else
                write_half_period(half_t'($urandom_range(1, 4)));
            repeat (8)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    it = tick_item(SDA_RANDOM);
                    if ($urandom_range(0, 1) == 0)
                        it.op = OP_RESERVED;
                    send_item(it);
                end
                else
                    run_command(3'($urandom_range(OP_START, OP_NACK)),
                                1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)), SDA_RANDOM, 8);
            end
        end
    endtask

    task automatic test_steady_stream();
        wait_drain();
        src_gaps = 1'b0;
        sink_stalls <= 1'b0;
        write_half_period(16'd2);
        repeat (6)
            run_command(3'($urandom_range(OP_START, OP_NACK)), 1'($urandom_range(0, 1)),
                        8'($urandom_range(0, 255)), SDA_RANDOM, 5);
    endtask

    initial
    begin
        clear_bus_model();
        rst_n              <= 1'b0;
        cfg_write_en       <= 1'b0;
        cfg_write_data     <= '0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_TICK;
        cmd_ch.bus_select  <= 1'b0;
        cmd_ch.write_byte  <= '0;
        cmd_ch.sda_in_bus0 <= 1'b1;
        cmd_ch.sda_in_bus1 <= 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_items();
        test_each_command();
        test_rejected_commands();
        test_zero_period();
        test_period_change_while_busy();
        test_back_pressure();
        test_random_traffic(ITEM_TARGET - 150);
        test_steady_stream();
        wait_drain();
        repeat (4) @(posedge clk);
        if (pending_status.size() != 0)
        begin
            $error("%0d status items never arrived", pending_status.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall bursts plus one long hold on request
    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left = 0;
        hold_seen  = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_ask)
            begin
                hold_seen  = hold_ask;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && sink_stalls && $urandom_range(0, 4) == 0)
                stall_left = $urandom_range(1, 7);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    function automatic void compare_field(input string field, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", field, want, got);
            mismatches++;
        end
    endfunction

    initial
    begin
        status_t want;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            begin
                if (pending_status.size() == 0)
                begin
                    $error("status item with no expectation waiting");
                    mismatches++;
                end
                else
                begin
                    want = pending_status.pop_front();
                    compare_field("scl_bus0", 8'(want.scl_bus0), 8'(res_ch.scl_bus0));
                    compare_field("sda_bus0", 8'(want.sda_bus0), 8'(res_ch.sda_bus0));
                    compare_field("scl_bus1", 8'(want.scl_bus1), 8'(res_ch.scl_bus1));
                    compare_field("sda_bus1", 8'(want.sda_bus1), 8'(res_ch.sda_bus1));
                    compare_field("busy_res", 8'(want.busy_res), 8'(res_ch.busy_res));
                    compare_field("done_res", 8'(want.done_res), 8'(res_ch.done_res));
                    compare_field("ack_seen", 8'(want.ack_seen), 8'(res_ch.ack_seen));
                    compare_field("read_data", want.read_data, res_ch.read_data);
                    compare_field("rejected", 8'(want.rejected), 8'(res_ch.rejected));
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
                (res_ch.valid === 1'b1 && res_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/i2c_seq_pkg.sv
rtl/i2c_seq_if.sv
rtl/i2c_master_bit_sequencer.sv
test/tb.sv
